### design/wcp_pkg.sv
// ----------------------------------------------------------------------------
// wcp_pkg
// Shared constants for the wall column projector: register indexes and the
// fixed widths of the shade arithmetic.
// ----------------------------------------------------------------------------
package wcp_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_PITCH = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RAY_DISTANCE = 4'd3;

  localparam logic [23:0] MAX_RAY_DISTANCE_RST = 24'd1310720;

  // shade = 255 * rem / M, or 1785 * rem / (10 * M) on vertical faces
  localparam int SHADE_NUM_W = 35;
  localparam int SHADE_DEN_W = 28;
  localparam logic [SHADE_NUM_W-1:0] SHADE_SCALE = 35'd255;
  localparam logic [SHADE_NUM_W-1:0] SHADE_SCALE_VERT = 35'd1785;

  // wide enough for any texture width up to 1024 texels
  localparam int TEXEL_W = 11;

endpackage

### design/wall_column_projector.sv
// ----------------------------------------------------------------------------
// wall_column_projector
// Projects one cast ray per screen column onto a wall strip: top and bottom
// rows, texel column, distance shade and texture number.
// ----------------------------------------------------------------------------
// Usage:
//   Rays enter on the s_ group, one per cycle at most; tuser bit 0 is the hit
//   flag, bit 1 the vertical face flag. A ray with hit low is dropped and
//   gives no result. Results leave on the m_ group in input order.
//   Configuration writes arrive on the cfg_ channel (always ready) and must
//   only be made while no ray is in flight.
// Pipeline: a ray passes the accepted-ray, product and operand stages, then
//   the NUM_W stages of the strip height divider, where NUM_W =
//   clog2(SCREEN_HEIGHT+1) + 32, and then the output register.
// Throughput: one ray per cycle unless the receiver stalls; the divider
//   pipelines set the depth, one quotient bit per stage.
// Reset clears all valid bits and loads the register defaults (player at the
//   origin, no pitch, full shade range of 20 cells).
// When the receiver stalls, the whole pipeline holds and s_tready falls; no
//   request is lost or repeated.
// ----------------------------------------------------------------------------
module wall_column_projector
  import wcp_pkg::*;
#(
  parameter int SCREEN_HEIGHT = 480,
  parameter int TEX_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // column[9:0], distance[33:10], dir_x[51:34], dir_y[69:52], wall_type[74:70]
  input  logic [79:0]           s_tdata,
  // hit[0], vertical_side[1]
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_column[9:0], top_row[25:10], bottom_row[41:26], texture_column[47:42],
  // shade[55:48], texture_index[59:56]
  output logic [63:0]           m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NUM_W = $clog2(SCREEN_HEIGHT + 1) + 32;
  localparam int BW = NUM_W + 2;
  localparam int TAG_W = 10 + 6 + 4 + 1;

  // configuration registers
  logic [23:0]          player_x;
  logic [23:0]          player_y;
  logic signed [10:0]   view_pitch;
  logic [23:0]          max_ray_distance;
  logic signed [BW-1:0] row_base;

  logic adv;

  // stage 1: accepted ray
  logic               s1_vld;
  logic [9:0]         s1_column;
  logic               s1_vert;
  logic [23:0]        s1_dist;
  logic signed [17:0] s1_dx;
  logic signed [17:0] s1_dy;
  logic [4:0]         s1_wt;

  // stage 2: products and range
  logic                    s2_vld;
  logic [9:0]              s2_column;
  logic                    s2_vert;
  logic [23:0]             s2_dist;
  logic                    s2_mirror;
  logic [3:0]              s2_tidx;
  logic [31:0]             s2_frac;
  logic [23:0]             s2_rem;
  logic                    s2_dark;
  logic [SHADE_DEN_W-1:0]  s2_den;
  logic signed [42:0]      prod;
  logic [SHADE_DEN_W-1:0]  m_ext;

  // stage 3: divider operands, texel column
  logic                    s3_vld;
  logic [9:0]              s3_column;
  logic [23:0]             s3_dist;
  logic [3:0]              s3_tidx;
  logic [5:0]              s3_tcol;
  logic                    s3_dark;
  logic [SHADE_NUM_W-1:0]  s3_num;
  logic [SHADE_DEN_W-1:0]  s3_den;
  logic [42:0]             tprod;
  logic [TEXEL_W-1:0]      texel;
  logic [TEXEL_W-1:0]      texel_m;

  // divider outputs
  logic               lh_vld;
  logic [NUM_W-1:0]   lh;
  logic [TAG_W-1:0]   lh_tag;
  logic               sh_vld;
  logic [NUM_W-1:0]   sh_q;
  logic               sh_dark;
  logic [TAG_W-1:0]   in_tag;

  // output stage
  logic signed [BW-1:0] top_sum;
  logic signed [BW-1:0] bot_sum;
  logic signed [BW-1:0] top_sh;
  logic signed [BW-1:0] bot_sh;
  logic [15:0]          top_sat;
  logic [15:0]          bot_sat;
  logic                 o_dzero;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x         <= '0;
      player_y         <= '0;
      view_pitch       <= '0;
      max_ray_distance <= MAX_RAY_DISTANCE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PLAYER_X:         player_x <= cfg_data;
        REG_PLAYER_Y:         player_y <= cfg_data;
        REG_VIEW_PITCH:       view_pitch <= cfg_data[10:0];
        REG_MAX_RAY_DISTANCE: max_ray_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // centre row of the strip in Q.17 rows, tracks the pitch register
  always_ff @(posedge clk) begin
    row_base <= BW'(SCREEN_HEIGHT) * BW'(65536) + (BW'(view_pitch) <<< 17);
  end

  // hold every stage while the output register is full and not taken
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= s_tvalid && s_tuser[0];
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_column <= s_tdata[9:0];
      s1_dist   <= s_tdata[33:10];
      s1_dx     <= s_tdata[51:34];
      s1_dy     <= s_tdata[69:52];
      s1_wt     <= s_tdata[74:70];
      s1_vert   <= s_tuser[1];
    end
  end

  assign prod  = $signed({1'b0, s1_dist}) * (s1_vert ? s1_dy : s1_dx);
  assign m_ext = SHADE_DEN_W'(max_ray_distance);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_column <= s1_column;
      s2_vert   <= s1_vert;
      s2_dist   <= s1_dist;
      s2_tidx   <= s1_wt[3:0] - 4'd1;
      s2_mirror <= s1_vert ? s1_dx[17] : (!s1_dy[17] && (s1_dy != '0));
      s2_frac   <= {(s1_vert ? player_y[15:0] : player_x[15:0]), 16'h0000}
                   + prod[31:0];
      s2_rem    <= max_ray_distance - s1_dist;
      s2_dark   <= (max_ray_distance == '0) || (s1_dist >= max_ray_distance);
      s2_den    <= s1_vert ? ((m_ext << 3) + (m_ext << 1)) : m_ext;
    end
  end

  assign tprod   = 43'(s2_frac) * 43'(TEX_WIDTH);
  assign texel   = tprod[42:32];
  assign texel_m = s2_mirror ? (TEXEL_W'(TEX_WIDTH - 1) - texel) : texel;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_column <= s2_column;
      s3_dist   <= s2_dist;
      s3_tidx   <= s2_tidx;
      s3_tcol   <= texel_m[5:0];
      s3_dark   <= s2_dark;
      s3_num    <= SHADE_NUM_W'(s2_rem)
                   * (s2_vert ? SHADE_SCALE_VERT : SHADE_SCALE);
      s3_den    <= s2_den;
    end
  end

  assign in_tag = {(s3_dist == '0), s3_tidx, s3_tcol, s3_column};

  // strip height: (SCREEN_HEIGHT << 32) / distance
  wcp_div #(
    .NUM_W(NUM_W),
    .DEN_W(SHADE_DEN_W),
    .TAG_W(TAG_W)
  ) u_height_div (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .in_vld (s3_vld),
    .num    (NUM_W'(SCREEN_HEIGHT) << 32),
    .den    (SHADE_DEN_W'(s3_dist)),
    .tag    (in_tag),
    .out_vld(lh_vld),
    .quot   (lh),
    .out_tag(lh_tag)
  );

  wcp_div #(
    .NUM_W(NUM_W),
    .DEN_W(SHADE_DEN_W),
    .TAG_W(1)
  ) u_shade_div (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .in_vld (s3_vld),
    .num    (NUM_W'(s3_num)),
    .den    (s3_den),
    .tag    (s3_dark),
    .out_vld(sh_vld),
    .quot   (sh_q),
    .out_tag(sh_dark)
  );

  assign o_dzero = lh_tag[TAG_W-1];
  assign top_sum = row_base - $signed({2'b00, lh});
  assign bot_sum = row_base + $signed({2'b00, lh});
  assign top_sh  = top_sum >>> 17;
  assign bot_sh  = bot_sum >>> 17;

  always_comb begin
    if (o_dzero || top_sh < -BW'(32768)) begin
      top_sat = 16'h8000;
    end else if (top_sh > BW'(32767)) begin
      top_sat = 16'h7fff;
    end else begin
      top_sat = top_sh[15:0];
    end
    if (o_dzero || bot_sh > BW'(32767)) begin
      bot_sat = 16'h7fff;
    end else if (bot_sh < -BW'(32768)) begin
      bot_sat = 16'h8000;
    end else begin
      bot_sat = bot_sh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= lh_vld && sh_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {4'h0,
                  lh_tag[19:16],
                  (sh_dark ? 8'h00 : sh_q[7:0]),
                  lh_tag[15:10],
                  bot_sat,
                  top_sat,
                  lh_tag[9:0]};
    end
  end

endmodule

### design/wcp_div.sv
// ----------------------------------------------------------------------------
// wcp_div
// Restoring divider, one quotient bit per register stage, with a sideband
// tag and valid bit that travel alongside. All stages advance on en.
// ----------------------------------------------------------------------------
module wcp_div #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 28,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag,
  output logic             out_vld,
  output logic [NUM_W-1:0] quot,
  output logic [TAG_W-1:0] out_tag
);

  logic             vld   [NUM_W];
  logic [DEN_W-1:0] rem   [NUM_W];
  logic [NUM_W-1:0] nsh   [NUM_W];
  logic [NUM_W-1:0] q     [NUM_W];
  logic [DEN_W-1:0] dreg  [NUM_W];
  logic [TAG_W-1:0] treg  [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic             vld_in;
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] q_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign vld_in = in_vld;
      assign rem_in = '0;
      assign num_in = num;
      assign q_in   = '0;
      assign den_in = den;
      assign tag_in = tag;
    end else begin : g_next
      assign vld_in = vld[s-1];
      assign rem_in = rem[s-1];
      assign num_in = nsh[s-1];
      assign q_in   = q[s-1];
      assign den_in = dreg[s-1];
      assign tag_in = treg[s-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nsh[s]  <= num_in << 1;
        q[s]    <= {q_in[NUM_W-2:0], ge};
        dreg[s] <= den_in;
        treg[s] <= tag_in;
      end
    end
  end

  assign out_vld = vld[NUM_W-1];
  assign quot    = q[NUM_W-1];
  assign out_tag = treg[NUM_W-1];

endmodule
